// ===== rtl/core/bbsf_pkg.sv =====
// Shared types and constants of the bounded byte stream FIFO
package bbsf_pkg;

    localparam int DEPTH_DEFAULT  = 4096;
    localparam int FIELD_CNT_W    = 13;
    localparam int TOTAL_W        = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    // register indexes, taken from paddr above the byte offset
    localparam logic [CFG_ADDR_W-3:0] REG_CAPACITY = '0;

    localparam logic [FIELD_CNT_W-1:0] CAPACITY_RESET = 13'd4096;

    typedef struct packed {
        logic       push_valid;
        logic [7:0] push_byte;
        logic       pop_valid;
        logic       close_input;
    } in_t;

    typedef struct packed {
        logic                   push_accepted;
        logic                   head_valid;
        logic [7:0]             head_byte;
        logic [FIELD_CNT_W-1:0] occupancy;
        logic [FIELD_CNT_W-1:0] space_left;
        logic                   input_closed;
        logic                   end_of_stream;
        logic [TOTAL_W-1:0]     total_written;
        logic [TOTAL_W-1:0]     total_read;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// ===== rtl/core/bbsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bbsf_ctrl.sv =====
// Sequencing state machine: accept an item, then commit it to the result register
module bbsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bbsf_pkg::status_t status,
    output bbsf_pkg::cmd_t    cmd
);

    bbsf_pkg::state_t state_reg;
    bbsf_pkg::state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            bbsf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bbsf_pkg::ST_EXEC;
                end
            end
            bbsf_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = bbsf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbsf_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbsf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/bbsf_datapath.sv =====
// Pointers, counters, byte store and result register of the byte FIFO
module bbsf_datapath #(
    parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bbsf_pkg::cmd_t                   cmd,
    output bbsf_pkg::status_t                status,
    input  bbsf_pkg::in_t                    in_data,
    input  logic [bbsf_pkg::FIELD_CNT_W-1:0] capacity,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bbsf_pkg::out_t                   out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > bbsf_pkg::FIELD_CNT_W) ? CNT_W : bbsf_pkg::FIELD_CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(DEPTH);
    localparam int TW = bbsf_pkg::TOTAL_W;

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next, fill_after_pop;
    logic             ended_reg, ended_next;
    logic [TW-1:0]    wcnt_reg, wcnt_next;
    logic [TW-1:0]    rcnt_reg, rcnt_next;
    bbsf_pkg::in_t    item_reg;
    logic             out_valid_reg;
    bbsf_pkg::out_t   out_data_reg, out_data_next;

    logic [7:0]       ram_q;
    logic             head_v;
    logic             do_pop;
    logic             do_push;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] space;

    // byte store, read port always follows the read pointer
    bbsf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.commit && do_push),
        .waddr (wr_ptr_reg),
        .wdata (item_reg.push_byte),
        .raddr (rd_ptr_reg),
        .rdata (ram_q)
    );

    // limit in force
    always_comb
    begin
        lim = (LIM_W'(capacity) < DEPTH_LIM) ? LIM_W'(capacity) : DEPTH_LIM;
    end

    // pop, then push, then close
    always_comb
    begin
        head_v         = (fill_reg != '0);
        do_pop         = item_reg.pop_valid && head_v;
        fill_after_pop = fill_reg - CNT_W'(do_pop);
        do_push        = item_reg.push_valid && !ended_reg && (LIM_W'(fill_after_pop) < lim);
        fill_next      = fill_after_pop + CNT_W'(do_push);
        ended_next     = ended_reg || item_reg.close_input;

        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end

        // saturating byte counters
        wcnt_next = (do_push && wcnt_reg != '1) ? wcnt_reg + TW'(1) : wcnt_reg;
        rcnt_next = (do_pop && rcnt_reg != '1) ? rcnt_reg + TW'(1) : rcnt_reg;

        space = (LIM_W'(fill_next) < lim) ? lim - LIM_W'(fill_next) : '0;

        out_data_next.push_accepted = do_push;
        out_data_next.head_valid    = head_v;
        out_data_next.head_byte     = head_v ? ram_q : 8'd0;
        out_data_next.occupancy     = bbsf_pkg::FIELD_CNT_W'(fill_next);
        out_data_next.space_left    = bbsf_pkg::FIELD_CNT_W'(space);
        out_data_next.input_closed  = ended_next;
        out_data_next.end_of_stream = ended_next && (fill_next == '0);
        out_data_next.total_written = wcnt_next;
        out_data_next.total_read    = rcnt_next;
    end

    // stream state, updated when an item commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            ended_reg     <= 1'b0;
            wcnt_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                fill_reg      <= fill_next;
                ended_reg     <= ended_next;
                wcnt_reg      <= wcnt_next;
                rcnt_reg      <= rcnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// ===== rtl/core/bounded_byte_stream_fifo_unit.sv =====
// Bounded byte FIFO top level: capacity register port, controller and datapath
// An accepted item is held in the input register; in the update state it is
// committed to the result register, which raises out_valid. No new item is
// taken until the item in hand commits; the result register stalls the
// update only while an earlier result is still waiting.
// Reset clears pointers, fill count, closed flag, counters; capacity reads 4096.
module bounded_byte_stream_fifo_unit #(
    parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bbsf_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bbsf_pkg::out_t                  out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbsf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bbsf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bbsf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [bbsf_pkg::FIELD_CNT_W-1:0] cap_reg;
    logic [bbsf_pkg::CFG_ADDR_W-3:0]  reg_index;
    bbsf_pkg::cmd_t                   cmd;
    bbsf_pkg::status_t                status;

    assign pready    = 1'b1;
    assign reg_index = paddr[bbsf_pkg::CFG_ADDR_W-1:2];

    // capacity register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bbsf_pkg::CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && reg_index == bbsf_pkg::REG_CAPACITY)
        begin
            cap_reg <= pwdata[bbsf_pkg::FIELD_CNT_W-1:0];
        end
    end

    // register read
    always_comb
    begin
        prdata = '0;
        if (reg_index == bbsf_pkg::REG_CAPACITY)
        begin
            prdata = bbsf_pkg::CFG_DATA_W'(cap_reg);
        end
    end

    bbsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bbsf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .capacity  (cap_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/bbsf_checker.sv =====
// Port-level checks of the byte FIFO and their bind to the top level
module bbsf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input bbsf_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input bbsf_pkg::out_t out_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an accepted transfer keeps the input closed for the update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken during update");

    // end of stream only when closed and empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_stream |->
            out_data.input_closed && out_data.occupancy == '0)
        else $error("end of stream while open or holding bytes");

    // no head and no push leaves the store empty, head byte zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.head_valid && !out_data.push_accepted |->
            out_data.occupancy == '0 && out_data.head_byte == 8'd0)
        else $error("empty store reported bytes");

endmodule

bind bounded_byte_stream_fifo_unit bbsf_checker u_bbsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
